/* hw/rtl/gpr_pkg.sv */
// ============================================================================
// gpr_pkg
// Shared types and constants for the gamepad report builder.
// ============================================================================
`default_nettype none

package gpr_pkg;

    // Field widths of the poll and report payloads
    localparam int SAMPLE_BITS  = 12;
    localparam int BUTTON_COUNT = 12;
    localparam int HAT_BITS     = 12;
    localparam int AXIS_BITS    = 8;
    localparam int HAT_CODE_BITS = 4;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CENTER_BITS    = 12;
    localparam int DEAD_ZONE_BITS = 11;
    localparam int LONG_PRESS_BITS = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_AXIS_CENTER   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEAD_ZONE     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_PRESS_MS = 2'd2;

    localparam logic [CENTER_BITS-1:0]     AXIS_CENTER_RESET   = 12'd2048;
    localparam logic [DEAD_ZONE_BITS-1:0]  DEAD_ZONE_RESET     = 11'd300;
    localparam logic [LONG_PRESS_BITS-1:0] LONG_PRESS_MS_RESET = 16'd10000;

    // Hat codes, clockwise from up
    localparam logic [HAT_CODE_BITS-1:0] HAT_UP         = 4'd0;
    localparam logic [HAT_CODE_BITS-1:0] HAT_UP_RIGHT   = 4'd1;
    localparam logic [HAT_CODE_BITS-1:0] HAT_RIGHT      = 4'd2;
    localparam logic [HAT_CODE_BITS-1:0] HAT_DOWN_RIGHT = 4'd3;
    localparam logic [HAT_CODE_BITS-1:0] HAT_DOWN       = 4'd4;
    localparam logic [HAT_CODE_BITS-1:0] HAT_DOWN_LEFT  = 4'd5;
    localparam logic [HAT_CODE_BITS-1:0] HAT_LEFT       = 4'd6;
    localparam logic [HAT_CODE_BITS-1:0] HAT_UP_LEFT    = 4'd7;
    localparam logic [HAT_CODE_BITS-1:0] HAT_NEUTRAL    = 4'd8;

    localparam logic [AXIS_BITS-1:0] AXIS_REST = 8'h80;

    // One poll
    typedef struct packed {
        logic [BUTTON_COUNT-1:0] button_levels;
        logic [31:0]             now_ms;
        logic [SAMPLE_BITS-1:0]  left_x;
        logic [SAMPLE_BITS-1:0]  left_y;
        logic [SAMPLE_BITS-1:0]  right_x;
        logic [SAMPLE_BITS-1:0]  right_y;
        logic [HAT_BITS-1:0]     hat_x;
        logic [HAT_BITS-1:0]     hat_y;
    } poll_t;

    // One result
    typedef struct packed {
        logic [HAT_CODE_BITS-1:0] hat_code;
        logic [BUTTON_COUNT-1:0]  button_bits;
        logic [AXIS_BITS-1:0]     left_x_byte;
        logic [AXIS_BITS-1:0]     left_y_byte;
        logic [AXIS_BITS-1:0]     right_x_byte;
        logic [AXIS_BITS-1:0]     right_y_byte;
        logic                     report_changed;
        logic                     reboot_request;
    } pad_report_t;

    // Stored copy of the last report
    typedef struct packed {
        logic [HAT_CODE_BITS-1:0] hat;
        logic [BUTTON_COUNT-1:0]  buttons;
        logic [AXIS_BITS-1:0]     lx;
        logic [AXIS_BITS-1:0]     ly;
        logic [AXIS_BITS-1:0]     rx;
        logic [AXIS_BITS-1:0]     ry;
    } last_t;

endpackage

`default_nettype wire

/* hw/rtl/gpr_hat.sv */
// ============================================================================
// gpr_hat
// Maps the two hat-axis samples to an eight-way hat code or neutral.
// ============================================================================
`default_nettype none

module gpr_hat (
    input  wire logic [gpr_pkg::HAT_BITS-1:0]       hat_x,
    input  wire logic [gpr_pkg::HAT_BITS-1:0]       hat_y,
    input  wire logic [gpr_pkg::CENTER_BITS-1:0]    axis_center,
    input  wire logic [gpr_pkg::DEAD_ZONE_BITS-1:0] dead_zone,
    output logic      [gpr_pkg::HAT_CODE_BITS-1:0]  hat_code
);
    import gpr_pkg::*;

    // Signed offsets wide enough for +-4095 and their negation
    localparam int DW = HAT_BITS + 2;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] ax;
    logic signed [DW-1:0] ay;
    logic signed [DW-1:0] dz;
    logic xc, yc, up, down, right, left;

    // Offsets from center and their magnitudes
    always_comb
    begin
        dx = $signed({2'b00, hat_x}) - $signed({{(DW-CENTER_BITS){1'b0}}, axis_center});
        dy = $signed({2'b00, hat_y}) - $signed({{(DW-CENTER_BITS){1'b0}}, axis_center});
        dz = $signed({{(DW-DEAD_ZONE_BITS){1'b0}}, dead_zone});
        ax = dx[DW-1] ? -dx : dx;
        ay = dy[DW-1] ? -dy : dy;
        xc    = ax < dz;
        yc    = ay < dz;
        up    = dy > dz;
        down  = dy < -dz;
        right = dx > dz;
        left  = dx < -dz;
    end

    // Direction decision, cardinals first
    always_comb
    begin
        priority if (up && xc)      hat_code = HAT_UP;
        else if (down && xc)        hat_code = HAT_DOWN;
        else if (left && yc)        hat_code = HAT_LEFT;
        else if (right && yc)       hat_code = HAT_RIGHT;
        else if (right && up)       hat_code = HAT_UP_RIGHT;
        else if (left && up)        hat_code = HAT_UP_LEFT;
        else if (right && down)     hat_code = HAT_DOWN_RIGHT;
        else if (left && down)      hat_code = HAT_DOWN_LEFT;
        else                        hat_code = HAT_NEUTRAL;
    end

endmodule

`default_nettype wire

/* hw/rtl/gamepad_report_builder.sv */
// ============================================================================
// gamepad_report_builder
// Builds gamepad reports from polls; emits only on change or reboot request.
// ============================================================================
//
//  channel   direction  handshake                 payload
//  poll      in         poll_valid / poll_stall   gpr_pkg::poll_t
//  report    out        report_valid/report_stall gpr_pkg::pad_report_t
//  cfg       in         cfg_we                    cfg_index, cfg_data
//
//  One poll per cycle while poll_stall is low; a poll passes through the input register, then
//  hat decode, compare and press timing into the report register.
//  Reset restores the register defaults and the neutral last report.
//  poll_stall rises only while the input register holds a poll that yields a
//  report and the report register is still full and stalled.
//
`default_nettype none

module gamepad_report_builder (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                poll_valid,
    output logic                                     poll_stall,
    input  wire gpr_pkg::poll_t                      poll,
    output logic                                     report_valid,
    input  wire logic                                report_stall,
    output gpr_pkg::pad_report_t                     report,
    input  wire logic                                cfg_we,
    input  wire logic [gpr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [gpr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import gpr_pkg::*;

    // Configuration registers
    logic [CENTER_BITS-1:0]     axis_center_reg;
    logic [DEAD_ZONE_BITS-1:0]  dead_zone_reg;
    logic [LONG_PRESS_BITS-1:0] long_press_ms_reg;

    // Pipeline registers
    logic        in_valid_reg;
    poll_t       in_reg;
    logic        out_valid_reg;
    pad_report_t out_reg;

    // Block state
    last_t       last_reg;
    last_t       last_next;
    logic        sys_reg;
    logic [31:0] press_start_reg;

    logic [HAT_CODE_BITS-1:0] hat_code;
    logic        sys;
    logic        reboot;
    logic        changed;
    logic        emit;
    logic        out_free;
    logic        advance;
    logic [31:0] duration;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_center_reg   <= AXIS_CENTER_RESET;
            dead_zone_reg     <= DEAD_ZONE_RESET;
            long_press_ms_reg <= LONG_PRESS_MS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_AXIS_CENTER:   axis_center_reg   <= cfg_data[CENTER_BITS-1:0];
                CFG_DEAD_ZONE:     dead_zone_reg     <= cfg_data[DEAD_ZONE_BITS-1:0];
                CFG_LONG_PRESS_MS: long_press_ms_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    gpr_hat u_hat (
        .hat_x       (in_reg.hat_x),
        .hat_y       (in_reg.hat_y),
        .axis_center (axis_center_reg),
        .dead_zone   (dead_zone_reg),
        .hat_code    (hat_code)
    );

    // Report assembly and change / press detection
    always_comb
    begin
        last_next.hat     = hat_code;
        last_next.buttons = in_reg.button_levels;
        last_next.lx      = in_reg.left_x[SAMPLE_BITS-1 -: AXIS_BITS];
        last_next.ly      = in_reg.left_y[SAMPLE_BITS-1 -: AXIS_BITS];
        last_next.rx      = in_reg.right_x[SAMPLE_BITS-1 -: AXIS_BITS];
        last_next.ry      = in_reg.right_y[SAMPLE_BITS-1 -: AXIS_BITS];
        sys      = in_reg.button_levels[0];
        duration = in_reg.now_ms - press_start_reg;
        reboot   = sys_reg && !sys && (duration >= {16'd0, long_press_ms_reg});
        changed  = last_next != last_reg;
        emit     = changed || reboot;
    end

    // Flow control
    assign out_free     = !out_valid_reg || !report_stall;
    assign advance      = in_valid_reg && (out_free || !emit);
    assign poll_stall   = in_valid_reg && !advance;
    assign report_valid = out_valid_reg;
    assign report       = out_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!poll_stall)
        begin
            in_valid_reg <= poll_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!poll_stall && poll_valid)
        begin
            in_reg <= poll;
        end
    end

    // State update on each consumed poll
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg.hat     <= HAT_NEUTRAL;
            last_reg.buttons <= '0;
            last_reg.lx      <= AXIS_REST;
            last_reg.ly      <= AXIS_REST;
            last_reg.rx      <= AXIS_REST;
            last_reg.ry      <= AXIS_REST;
            sys_reg          <= 1'b0;
            press_start_reg  <= '0;
        end
        else if (advance)
        begin
            last_reg <= last_next;
            sys_reg  <= sys;
            if (!sys_reg && sys)
            begin
                press_start_reg <= in_reg.now_ms;
            end
        end
    end

    // Report register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && advance && emit)
        begin
            out_reg.hat_code       <= last_next.hat;
            out_reg.button_bits    <= last_next.buttons;
            out_reg.left_x_byte    <= last_next.lx;
            out_reg.left_y_byte    <= last_next.ly;
            out_reg.right_x_byte   <= last_next.rx;
            out_reg.right_y_byte   <= last_next.ry;
            out_reg.report_changed <= changed;
            out_reg.reboot_request <= reboot;
        end
    end

endmodule

`default_nettype wire
